// File: design/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the four-layer alpha compositor.
// ----------------------------------------------------------------------------
package afc_pkg;

    // channel and layer widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned NUM_LYR  = 4;
    localparam int unsigned LAYER_W  = 32;
    localparam int unsigned SUM_W    = 16;

    // full-scale channel value, used as the alpha complement base
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // register map
    localparam logic [0:0] REG_BG_GRAY = 1'b0;
    localparam logic [CHAN_W-1:0] BG_GRAY_RESET = 8'd255;

    typedef logic [CHAN_W-1:0]           chan_t;
    typedef chan_t [NUM_CH-1:0]          rgb_t;     // [0] blue, [1] green, [2] red
    typedef logic [LAYER_W-1:0]          layer_t;   // blue, green, red, alpha
    typedef layer_t [NUM_LYR-1:0]        layers_t;  // [0] back ... [3] front
    typedef logic [SUM_W-1:0]            sum_t;
    typedef sum_t [NUM_CH-1:0]           sums_t;

    // pixel between layer steps: running channels plus all four layers
    typedef struct packed {
        layers_t layers;
        rgb_t    ch;
    } pix_t;

    // weighted sums before the divide by 255
    typedef struct packed {
        layers_t layers;
        sums_t   sum;
    } acc_t;

endpackage

// File: design/four_layer_alpha_compositor.sv
// ----------------------------------------------------------------------------
// four_layer_alpha_compositor
// Blends four RGBA layers over a gray background, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// pipeline: a multiply register and a normalize register per layer, the last
//   normalize register is the output register
// throughput: one pixel per cycle while m_tready is high
// reset: rst_n clears all stage valid bits and sets background_gray to 255
// ----------------------------------------------------------------------------
module four_layer_alpha_compositor
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // back_layer, word_layer, pattern_layer, front_layer
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // out_pixel
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    afc_pkg::chan_t gray_reg;
    logic           cfg_wr;
    logic           ce;

    afc_pkg::pix_t  stage_pix   [afc_pkg::NUM_LYR + 1];
    logic           stage_valid [afc_pkg::NUM_LYR + 1];
    afc_pkg::acc_t  stage_acc   [afc_pkg::NUM_LYR];
    logic           acc_valid   [afc_pkg::NUM_LYR];

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == afc_pkg::REG_BG_GRAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg <= afc_pkg::BG_GRAY_RESET;
        end
        else if (cfg_wr)
        begin
            gray_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == afc_pkg::REG_BG_GRAY) ? {24'd0, gray_reg} : 32'd0;

    // whole pipeline advances unless a finished pixel is held at the output
    assign ce       = !stage_valid[afc_pkg::NUM_LYR] || m_tready;
    assign s_tready = ce;

    // stage zero: unpack layers, start all channels at the gray level
    assign stage_valid[0]      = s_tvalid;
    assign stage_pix[0].layers = s_tdata;
    assign stage_pix[0].ch     = {afc_pkg::NUM_CH{gray_reg}};

    // one multiply and one normalize stage per layer
    for (genvar i = 0; i < afc_pkg::NUM_LYR; i++)
    begin : g_layer
        afc_mul u_mul
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (stage_valid[i]),
            .in_pix    (stage_pix[i]),
            .layer     (stage_pix[i].layers[i]),
            .out_valid (acc_valid[i]),
            .out_acc   (stage_acc[i])
        );

        afc_div u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (acc_valid[i]),
            .in_acc    (stage_acc[i]),
            .out_valid (stage_valid[i+1]),
            .out_pix   (stage_pix[i+1])
        );
    end

    // output
    assign m_tvalid = stage_valid[afc_pkg::NUM_LYR];
    assign m_tdata  = stage_pix[afc_pkg::NUM_LYR].ch;

endmodule

// File: design/afc_mul.sv
// ----------------------------------------------------------------------------
// afc_mul
// Multiply stage of one layer step: c*(255-a) + l*a per channel, registered.
// ----------------------------------------------------------------------------
module afc_mul
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ce,
    input  logic            in_valid,
    input  afc_pkg::pix_t   in_pix,
    input  afc_pkg::layer_t layer,
    output logic            out_valid,
    output afc_pkg::acc_t   out_acc
);

    logic          valid_reg;
    afc_pkg::acc_t acc_reg;
    afc_pkg::acc_t acc_next;
    afc_pkg::chan_t alpha;
    afc_pkg::chan_t alpha_inv;

    assign alpha     = layer[31:24];
    assign alpha_inv = afc_pkg::CHAN_MAX - alpha;

    // weighted sum per channel, at most 255*255
    always_comb
    begin
        acc_next.layers = in_pix.layers;
        for (int k = 0; k < afc_pkg::NUM_CH; k++)
        begin
            acc_next.sum[k] = {8'd0, in_pix.ch[k]} * {8'd0, alpha_inv}
                            + {8'd0, layer[8*k +: 8]} * {8'd0, alpha};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;

endmodule

// File: design/afc_div.sv
// ----------------------------------------------------------------------------
// afc_div
// Normalize stage of one layer step: floor(n/255) by add and shift, registered.
// ----------------------------------------------------------------------------
module afc_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_valid,
    input  afc_pkg::acc_t in_acc,
    output logic          out_valid,
    output afc_pkg::pix_t out_pix
);

    logic          valid_reg;
    afc_pkg::pix_t pix_reg;
    afc_pkg::pix_t pix_next;
    logic [16:0]   q_ext [afc_pkg::NUM_CH];

    // floor(n/255) = (n + (n >> 8) + 1) >> 8, exact for n up to 255*255
    always_comb
    begin
        pix_next.layers = in_acc.layers;
        for (int k = 0; k < afc_pkg::NUM_CH; k++)
        begin
            q_ext[k] = {1'b0, in_acc.sum[k]} + {9'd0, in_acc.sum[k][15:8]} + 17'd1;
            pix_next.ch[k] = q_ext[k][15:8];
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// File: design/afc_checker.sv
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks for the four-layer alpha compositor.
// ----------------------------------------------------------------------------
module afc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [0:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == afc_pkg::REG_BG_GRAY);

    // a stalled output transfer holds its pixel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output pixel changed while stalled");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a register write is seen on the next read
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (paddr != afc_pkg::REG_BG_GRAY) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("readback mismatch after write");

    // only eight register bits are implemented
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:8] == 24'd0)
        else $error("unimplemented register bits read nonzero");

endmodule

bind four_layer_alpha_compositor afc_checker u_afc_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-layer alpha compositor. Pixels go in on
// the input stream with random gaps, and each transfer is blended in the bench
// at the moment it is accepted. Output transfers are compared in order
// against those pixels while the output side stalls at random. The gray
// register is written over APB between phases and read back each time.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned LATENCY        = 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS    = 100;
    localparam logic [0:0]  BAD_REG_ADDR   = 1'b1;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // back_layer, word_layer, pattern_layer, front_layer
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;   // out_pixel
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [0:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // bench state
    logic [23:0]     pending_pixels[$];
    afc_pkg::chan_t  gray_model;
    int unsigned     mismatch_count;
    int unsigned     quiet_cycles;
    bit              idle_on;
    bit              rx_hold_req;

    four_layer_alpha_compositor dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // blend four layers over the gray level, one channel at a time
    function automatic logic [23:0] composite_pixel(input afc_pkg::chan_t gray,
                                                    input afc_pkg::layers_t lyr);
        afc_pkg::rgb_t ch;
        int unsigned   alpha;
        int unsigned   num;
        int unsigned   full;
        int            i;
        int            k;
        full = afc_pkg::CHAN_MAX;
        for (k = 0; k < afc_pkg::NUM_CH; k++)
            ch[k] = gray;
        for (i = 0; i < afc_pkg::NUM_LYR; i++)
        begin
            alpha = lyr[i][31:24];
            for (k = 0; k < afc_pkg::NUM_CH; k++)
            begin
                num   = ch[k] * (full - alpha) + lyr[i][8*k +: 8] * alpha;
                ch[k] = afc_pkg::chan_t'(num / full);
            end
        end
        return ch;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // layer with alpha biased toward the opaque and transparent ends
    function automatic afc_pkg::layer_t random_layer();
        afc_pkg::layer_t lyr;
        int unsigned     r;
        lyr = $urandom();
        r   = $urandom_range(0, 9);
        if (r < 2)
            lyr[31:24] = 8'h00;
        else if (r < 4)
            lyr[31:24] = 8'hFF;
        return lyr;
    endfunction

    // one input transfer; the expected pixel is queued when it is accepted
    task automatic send_pixel(input afc_pkg::layer_t back, input afc_pkg::layer_t word,
                              input afc_pkg::layer_t pattern, input afc_pkg::layer_t front);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {front, pattern, word, back};
        do
            @(posedge clk);
        while (!s_tready);
        pending_pixels.push_back(composite_pixel(gray_model, {front, pattern, word, back}));
    endtask

    // stop offering and wait until every expected pixel has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [0:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == afc_pkg::REG_BG_GRAY)
            gray_model = data[afc_pkg::CHAN_W-1:0];
    endtask

    // read the gray register back and compare with the bench copy
    task automatic check_gray_readback();
        logic [31:0] value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= afc_pkg::REG_BG_GRAY;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (value !== {24'd0, gray_model})
        begin
            $display("%0t readback background_gray: expected %08h actual %08h",
                     $time, {24'd0, gray_model}, value);
            mismatch_count++;
        end
    endtask

    task automatic set_gray(input logic [31:0] data);
        drain();
        apb_write(afc_pkg::REG_BG_GRAY, data);
        check_gray_readback();
    endtask

    // transparent layers leave the reset gray level
    task automatic test_reset_gray();
        idle_on = 1'b0;
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h00FF_FFFF, 32'h0012_3456, 32'h00AB_CDEF, 32'h00FF_FFFF);
        drain();
        check_gray_readback();
    endtask

    // field extremes, opaque and near-opaque layers, mid alpha
    task automatic test_extremes();
        idle_on = 1'b1;
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'hFF10_2030, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hFF11_2233, 32'hFF44_5566, 32'hFF77_8899, 32'hFFAB_CDEF);
        send_pixel(32'hFF00_0000, 32'h80FF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h01FF_00FF, 32'h0100_FF00, 32'h01FF_FF00, 32'h0100_00FF);
        send_pixel(32'hFE00_0000, 32'hFEFF_FFFF, 32'hFE12_3456, 32'hFE80_8080);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'h80AA_5500, 32'h7F00_55AA);
        send_pixel(32'h00FF_FFFF, 32'hFF00_0000, 32'h0000_0000, 32'h00FF_FFFF);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();
    endtask

    // register write, excess bits, write to an unmapped address
    task automatic test_registers();
        idle_on = 1'b0;
        set_gray(32'h0000_0000);
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h80FF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        set_gray(32'hABCD_EF5A);
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h40C0_2010, 32'h0000_0000, 32'h0000_0000, 32'h2000_0000);
        drain();
        apb_write(BAD_REG_ADDR, 32'h0000_0077);
        check_gray_readback();
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        set_gray(32'h0000_00FF);
    endtask

    // output held off while the input keeps offering, then a drain and random gaps
    task automatic test_backpressure();
        int i;
        idle_on     = 1'b0;
        rx_hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_pixel(random_layer(), random_layer(), random_layer(), random_layer());
        drain();
        idle_on = 1'b1;
        for (i = 0; i < 20; i++)
            send_pixel(random_layer(), random_layer(), random_layer(), random_layer());
    endtask

    // random pixels over several gray settings, idling in some stretches only
    task automatic test_random();
        logic [31:0] gray_values[7];
        int          ph;
        int          i;
        gray_values[0] = 32'h0000_0000;
        gray_values[1] = 32'h0000_00FF;
        for (ph = 2; ph < 7; ph++)
            gray_values[ph] = $urandom();
        for (ph = 0; ph < 7; ph++)
        begin
            set_gray(gray_values[ph]);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 25 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                send_pixel(random_layer(), random_layer(), random_layer(), random_layer());
            end
        end
    endtask

    // output side: random stalls, plus a long hold on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // compare each output transfer with the oldest expected pixel
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t unexpected out_pixel: expected none actual %06h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                if (m_tdata !== pending_pixels[0])
                begin
                    $display("%0t out_pixel mismatch: expected %06h actual %06h",
                             $time, pending_pixels[0], m_tdata);
                    mismatch_count++;
                end
                void'(pending_pixels.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        gray_model     = afc_pkg::BG_GRAY_RESET;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b0;
        rx_hold_req    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_gray();
        test_extremes();
        test_registers();
        test_backpressure();
        test_random();

        drain();
        repeat (LATENCY) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
